// ===== src/kway_merge_engine_macros.svh =====
// Assertion macros used by the checker file of the merge engine.
// Depends on nothing; included by bare file name.
`ifndef KWAY_MERGE_ENGINE_MACROS_SVH
`define KWAY_MERGE_ENGINE_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define KME_ASSERT_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("merge engine check failed");

// Implication whose consequent is checked in the cycle after, also across reset.
`define KME_ASSERT_NEXT(label, clk, cond, prop) \
  label: assert property (@(posedge clk) (cond) |=> (prop)) \
    else $error("merge engine check failed");

`endif

// ===== src/kme_pkg.sv =====
// Package of the k-way merge engine: default sizes, field widths and
// register indexes. Depends on nothing.
package kme_pkg;

  localparam int DEF_MAX_RUNS   = 16;
  localparam int DEF_KEY_BITS   = 64;
  localparam int DEF_VALUE_BITS = 64;

  // Fixed widths of the item fields.
  localparam int RUN_IDX_W = 4;
  localparam int KEY_W     = 64;
  localparam int VALUE_W   = 64;
  localparam int DATA_W    = KEY_W + VALUE_W;
  localparam int IN_USER_W = RUN_IDX_W + 1;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int RUNS_W     = 5;
  localparam int TOTAL_W    = 32;

  localparam logic REG_RUNS_IN_USE   = 1'b0;
  localparam logic REG_TOTAL_RECORDS = 1'b1;

  localparam logic [RUNS_W-1:0]  RUNS_RESET  = 5'd2;
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 32'd0;

endpackage

// ===== src/kway_merge_engine.sv =====
// Top level of the k-way merge engine: head store, linear min scan and
// output register. Depends on kme_pkg.
//
//   Channel  Direction  Accepted when            Carries
//   s_*      in         s_tvalid & s_tready      run record or run end mark
//   m_*      out        m_tvalid & m_tready      smallest head, source run, last flag
//   APB      in         psel&penable&pwrite      runs_in_use, total_records
//
// An input item is accepted only when the engine is idle. An item that
// causes no result goes from check back to idle. One that causes a result
// also runs scan, drain and emit, the scan covering every effective run:
// the head memory has one read port and is scanned one entry per cycle
// to find the smallest key. Reset is synchronous; it clears all flags and
// the count. A stall on the output only holds the engine once a second
// result is ready while the first still waits in the output register.
module kway_merge_engine #(
  parameter int MAX_RUNS   = kme_pkg::DEF_MAX_RUNS,
  parameter int KEY_BITS   = kme_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = kme_pkg::DEF_VALUE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input items.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // record_key [63:0], record_value [127:64]
  input  logic [kme_pkg::DATA_W-1:0]      s_tdata,
  // run_index [3:0], run_end [4]
  input  logic [kme_pkg::IN_USER_W-1:0]   s_tuser,
  // Result items.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // out_key [63:0], out_value [127:64]
  output logic [kme_pkg::DATA_W-1:0]      m_tdata,
  // source_run [3:0]
  output logic [kme_pkg::RUN_IDX_W-1:0]   m_tuser,
  // final_record
  output logic                            m_tlast,
  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kme_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kme_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kme_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  localparam int IDX_W  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CNT_W  = $clog2(MAX_RUNS + 1);
  // Wide enough for the run count, the 5-bit register and a run index.
  localparam int WIDE_W = (CNT_W > kme_pkg::RUNS_W) ? CNT_W : kme_pkg::RUNS_W;
  localparam int MEM_W  = KEY_BITS + VALUE_BITS;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [kme_pkg::RUNS_W-1:0]  runs_in_use;
  logic [kme_pkg::TOTAL_W-1:0] total_records;

  // Per-run flags; the head records themselves live in head_mem.
  logic [MAX_RUNS-1:0]         head_present;
  logic [MAX_RUNS-1:0]         run_exhausted;
  logic [kme_pkg::TOTAL_W-1:0] emitted_count;

  logic [MEM_W-1:0] head_mem [MAX_RUNS];
  logic [MEM_W-1:0] rd_data;

  // Scan pipeline: address stage and compare stage.
  logic [IDX_W-1:0]      scan_idx;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_vld;
  logic [KEY_BITS-1:0]   best_key;
  logic [VALUE_BITS-1:0] best_value;
  logic [IDX_W-1:0]      best_idx;
  logic                  best_found;

  // Output register.
  logic                          out_valid;
  logic [kme_pkg::DATA_W-1:0]    out_data;
  logic [kme_pkg::RUN_IDX_W-1:0] out_run;
  logic                          out_last;

  logic [WIDE_W-1:0]           n_eff;
  logic [WIDE_W-1:0]           last_idx;
  logic [WIDE_W-1:0]           run_ext;
  logic [IDX_W-1:0]            run_idx;
  logic                        run_active;
  logic                        run_end;
  logic                        in_accept;
  logic                        cfg_write;
  logic [MAX_RUNS-1:0]         active_mask;
  logic                        all_settled;
  logic                        any_present;
  logic                        can_load;
  logic [kme_pkg::TOTAL_W-1:0] count_inc;
  logic                        is_final;
  logic [KEY_BITS-1:0]         rd_key;
  logic [VALUE_BITS-1:0]       rd_value;
  logic                        rd_better;

  // A run count of zero acts as one run, any count above the maximum as the maximum.
  always_comb begin
    if (runs_in_use == '0) begin
      n_eff = WIDE_W'(1);
    end else if (WIDE_W'(runs_in_use) > WIDE_W'(MAX_RUNS)) begin
      n_eff = WIDE_W'(MAX_RUNS);
    end else begin
      n_eff = WIDE_W'(runs_in_use);
    end
  end

  assign last_idx   = n_eff - WIDE_W'(1);
  assign run_ext    = WIDE_W'(s_tuser[kme_pkg::RUN_IDX_W-1:0]);
  assign run_idx    = run_ext[IDX_W-1:0];
  assign run_active = run_ext < n_eff;
  assign run_end    = s_tuser[kme_pkg::RUN_IDX_W];

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;

  // The merge may emit only when every active run holds a head or has ended.
  always_comb begin
    for (int r = 0; r < MAX_RUNS; r++) begin
      active_mask[r] = WIDE_W'(r) < n_eff;
    end
  end

  assign all_settled = &(~active_mask | head_present | run_exhausted);
  assign any_present = |(active_mask & head_present);

  assign rd_key    = rd_data[KEY_BITS-1:0];
  assign rd_value  = rd_data[MEM_W-1:KEY_BITS];
  // Strictly smaller wins, so ties stay with the lower run index.
  assign rd_better = rd_vld && head_present[rd_idx] && (!best_found || rd_key < best_key);

  assign can_load  = !out_valid || m_tready;
  assign count_inc = emitted_count + kme_pkg::TOTAL_W'(1);
  assign is_final  = (count_inc == total_records);

  // Head store: written when a record is taken into a free head slot, read once per scan step.
  always_ff @(posedge clk) begin
    if (in_accept && run_active && !run_end && !head_present[run_idx] &&
        !run_exhausted[run_idx]) begin
      head_mem[run_idx] <= {s_tdata[kme_pkg::KEY_W +: VALUE_BITS], s_tdata[KEY_BITS-1:0]};
    end
    if (state == ST_SCAN) begin
      rd_data <= head_mem[scan_idx];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      runs_in_use   <= kme_pkg::RUNS_RESET;
      total_records <= kme_pkg::TOTAL_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        kme_pkg::REG_RUNS_IN_USE:   runs_in_use   <= pwdata[kme_pkg::RUNS_W-1:0];
        kme_pkg::REG_TOTAL_RECORDS: total_records <= pwdata[kme_pkg::TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      kme_pkg::REG_RUNS_IN_USE:   prdata = kme_pkg::APB_DATA_W'(runs_in_use);
      kme_pkg::REG_TOTAL_RECORDS: prdata = total_records;
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Sequencer, flags and emitted count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head_present  <= '0;
      run_exhausted <= '0;
      emitted_count <= '0;
      rd_vld        <= 1'b0;
      best_found    <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (run_active) begin
              if (run_end) begin
                run_exhausted[run_idx] <= 1'b1;
              end else if (!head_present[run_idx] && !run_exhausted[run_idx]) begin
                head_present[run_idx] <= 1'b1;
              end
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          best_found <= 1'b0;
          if (all_settled && any_present) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (rd_better) begin
            best_found <= 1'b1;
          end
          if (WIDE_W'(scan_idx) == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (rd_better) begin
            best_found <= 1'b1;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_load) begin
            if (is_final) begin
              head_present  <= '0;
              run_exhausted <= '0;
              emitted_count <= '0;
            end else begin
              head_present[best_idx] <= 1'b0;
              emitted_count          <= count_inc;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Scan address and best-so-far payload.
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    rd_idx <= scan_idx;
    if (rd_better) begin
      best_key   <= rd_key;
      best_value <= rd_value;
      best_idx   <= rd_idx;
    end
  end

  // Output register: takes a new result while the old one is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && can_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && can_load) begin
      out_data <= {kme_pkg::VALUE_W'(best_value), kme_pkg::KEY_W'(best_key)};
      out_run  <= kme_pkg::RUN_IDX_W'(best_idx);
      out_last <= is_final;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_run;
  assign m_tlast  = out_last;

endmodule

// ===== src/kme_checker.sv =====
// Port-level checks of the merge engine, bound to the top level.
// Depends on kme_pkg and kway_merge_engine_macros.svh.
`include "kway_merge_engine_macros.svh"

module kme_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kme_pkg::DATA_W-1:0]      m_tdata,
  input logic                            pready
);

  // A stalled result keeps its data.
  `KME_ASSERT_IMPLY(a_out_hold, clk, rst, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)))

  // Reset empties the output register.
  `KME_ASSERT_NEXT(a_reset_empty, clk, rst, !m_tvalid)

  // Items are taken one at a time: the engine is busy right after it takes one.
  `KME_ASSERT_IMPLY(a_busy_after_accept, clk, rst, s_tvalid && s_tready, ##1 !s_tready)

  // The configuration port never inserts wait states.
  `KME_ASSERT_IMPLY(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind kway_merge_engine kme_checker u_kme_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
